/* design/gdnc_pkg.sv */
package gdnc_pkg;

  localparam int unsigned BASE_YEAR     = 1601;
  localparam int unsigned DAYS_PER_YEAR = 365;
  localparam int unsigned CENTURY       = 100;
  localparam int unsigned QUAD_CENTURY  = 400;
  localparam int unsigned FEB_LEAP_DAYS = 29;
  localparam int unsigned MAX_YEAR_DEF  = 9999;

  // floor(x / 100) == (x * DIV100_MUL) >> DIV100_SH for x below 493447
  localparam int unsigned DIV100_MUL = 335545;
  localparam int unsigned DIV100_SH  = 25;

  localparam int DAYW  = 5;
  localparam int MONW  = 4;
  localparam int YEARW = 14;
  localparam int NUMW  = 22;
  localparam int STATW = 2;
  localparam int DOYW  = 9;

  localparam logic [MONW-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONW-1:0] MONTH_DEC = 4'd12;
  localparam logic [MONW-1:0] MONTH_JAN = 4'd1;

  localparam logic ACT_TO_NUM  = 1'b0;
  localparam logic ACT_TO_DATE = 1'b1;

  localparam logic [STATW-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATW-1:0] STATUS_BAD_DATE = 2'd1;
  localparam logic [STATW-1:0] STATUS_BAD_NUM  = 2'd2;

  localparam logic [1:0] RES_NUM   = 2'd0;
  localparam logic [1:0] RES_DATE  = 2'd1;
  localparam logic [1:0] RES_RANGE = 2'd2;

  localparam logic [DOYW-1:0] DAYS_BEFORE [2][13] = '{
    '{9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181, 9'd212, 9'd243, 9'd273,
      9'd304, 9'd334},
    '{9'd0, 9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182, 9'd213, 9'd244, 9'd274,
      9'd305, 9'd335}
  };

  localparam logic [DAYW-1:0] MONTH_LEN [13] = '{
    5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef struct packed {
    logic             action;
    logic [DAYW-1:0]  day_in;
    logic [MONW-1:0]  month_in;
    logic [YEARW-1:0] year_in;
    logic [NUMW-1:0]  day_number_in;
  } gdnc_in_t;

  typedef struct packed {
    logic [STATW-1:0] status;
    logic [NUMW-1:0]  day_number_out;
    logic [DAYW-1:0]  day_out;
    logic [MONW-1:0]  month_out;
    logic [YEARW-1:0] year_out;
  } gdnc_out_t;

  typedef struct packed {
    logic       load;
    logic       q_en;
    logic       leap_en;
    logic       w_en;
    logic       cmp_en;
    logic       yleap_en;
    logic       m_step;
    logic       out_load;
    logic [1:0] res_sel;
  } gdnc_cmd_t;

  typedef struct packed {
    logic action;
    logic num_bad;
    logic last_bit;
    logic month_more;
  } gdnc_sts_t;

endpackage

/* design/gdnc_ctrl.sv */
module gdnc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_action,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  gdnc_pkg::gdnc_sts_t sts,
  output gdnc_pkg::gdnc_cmd_t cmd
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_LQ   = 4'd1;
  localparam logic [3:0] ST_LP   = 4'd2;
  localparam logic [3:0] ST_WQ   = 4'd3;
  localparam logic [3:0] ST_WS   = 4'd4;
  localparam logic [3:0] ST_FIN0 = 4'd5;
  localparam logic [3:0] ST_CHK  = 4'd6;
  localparam logic [3:0] ST_CMP  = 4'd7;
  localparam logic [3:0] ST_YQ   = 4'd8;
  localparam logic [3:0] ST_YL   = 4'd9;
  localparam logic [3:0] ST_MS   = 4'd10;
  localparam logic [3:0] ST_FIN1 = 4'd11;
  localparam logic [3:0] ST_FINR = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = (in_action == gdnc_pkg::ACT_TO_DATE) ? ST_CHK : ST_LQ;
        end
      end
      ST_LQ: begin
        cmd.q_en  = 1'b1;
        state_nxt = ST_LP;
      end
      ST_LP: begin
        cmd.leap_en = 1'b1;
        state_nxt   = ST_WQ;
      end
      ST_WQ: begin
        cmd.q_en  = 1'b1;
        state_nxt = ST_WS;
      end
      ST_WS: begin
        cmd.w_en  = 1'b1;
        state_nxt = (sts.action == gdnc_pkg::ACT_TO_NUM) ? ST_FIN0 : ST_CMP;
      end
      ST_FIN0: begin
        cmd.res_sel = gdnc_pkg::RES_NUM;
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_CHK: begin
        state_nxt = sts.num_bad ? ST_FINR : ST_WQ;
      end
      ST_CMP: begin
        cmd.cmp_en = 1'b1;
        state_nxt  = sts.last_bit ? ST_YQ : ST_WQ;
      end
      ST_YQ: begin
        cmd.q_en  = 1'b1;
        state_nxt = ST_YL;
      end
      ST_YL: begin
        cmd.yleap_en = 1'b1;
        state_nxt    = ST_MS;
      end
      ST_MS: begin
        if (sts.month_more) begin
          cmd.m_step = 1'b1;
        end else begin
          state_nxt = ST_FIN1;
        end
      end
      ST_FIN1: begin
        cmd.res_sel = gdnc_pkg::RES_DATE;
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_FINR: begin
        cmd.res_sel = gdnc_pkg::RES_RANGE;
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != ST_IDLE))
    else $error("request accepted but controller stayed idle");

  a_result_from_final: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |->
      $past(state_r == ST_FIN0 || state_r == ST_FIN1 || state_r == ST_FINR))
    else $error("result raised outside a final state");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !cmd.out_load)
    else $error("result overwritten while stalled");
`endif

endmodule

/* design/gdnc_dp.sv */
module gdnc_dp #(
  parameter int unsigned MAX_YEAR = gdnc_pkg::MAX_YEAR_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  gdnc_pkg::gdnc_in_t  in_data,
  input  gdnc_pkg::gdnc_cmd_t cmd,
  output gdnc_pkg::gdnc_sts_t sts,
  output gdnc_pkg::gdnc_out_t out_data
);

  localparam int unsigned LAST_N   = MAX_YEAR - gdnc_pkg::BASE_YEAR + 1;
  localparam int unsigned LAST_DAY = LAST_N * gdnc_pkg::DAYS_PER_YEAR + LAST_N / 4
                                     - LAST_N / gdnc_pkg::CENTURY
                                     + LAST_N / gdnc_pkg::QUAD_CENTURY;
  localparam int YB   = $clog2(MAX_YEAR - gdnc_pkg::BASE_YEAR + 1);
  localparam int OPW  = $clog2(MAX_YEAR + 1);
  localparam int QW   = OPW - 6;
  localparam int WYDW = OPW + 9;
  localparam int PW   = OPW + 19;
  localparam int BCW  = (YB > 1) ? $clog2(YB) : 1;
  localparam int DOYW = gdnc_pkg::DOYW;
  localparam int MONW = gdnc_pkg::MONW;

  gdnc_pkg::gdnc_in_t  req_r;
  gdnc_pkg::gdnc_out_t out_r;
  gdnc_pkg::gdnc_out_t res_c;

  logic [OPW-1:0]  op_r;
  logic [QW-1:0]   q100_r;
  logic [WYDW-1:0] wyd_r;
  logic [WYDW-1:0] base_r;
  logic [YB-1:0]   y_r;
  logic [BCW-1:0]  bit_r;
  logic            lp_r;
  logic [DOYW-1:0] doy_r;
  logic [MONW-1:0] m_r;

  logic [PW-1:0]   qprod;
  logic [6:0]      rem100;
  logic            leap_c;
  logic [WYDW-1:0] wyd_c;
  logic            lt_c;
  logic [YB-1:0]   y_new;
  logic [MONW-1:0] m_inc;

  assign qprod  = PW'(op_r) * PW'(gdnc_pkg::DIV100_MUL);
  assign rem100 = 7'(op_r - OPW'(q100_r) * OPW'(gdnc_pkg::CENTURY));
  assign leap_c = (op_r[1:0] == 2'd0 && rem100 != 7'd0) ||
                  (rem100 == 7'd0 && q100_r[1:0] == 2'd0);
  assign wyd_c  = WYDW'(op_r) * WYDW'(gdnc_pkg::DAYS_PER_YEAR) + WYDW'(op_r >> 2)
                  - WYDW'(q100_r) + WYDW'(q100_r >> 2);
  assign lt_c   = 32'(wyd_r) < 32'(req_r.day_number_in);
  assign y_new  = lt_c ? YB'(op_r) : y_r;
  assign m_inc  = m_r + 4'd1;

  assign sts.action     = req_r.action;
  assign sts.num_bad    = (req_r.day_number_in == '0) ||
                          (32'(req_r.day_number_in) > LAST_DAY);
  assign sts.last_bit   = (bit_r == '0);
  assign sts.month_more = (m_r < gdnc_pkg::MONTH_DEC) &&
                          (doy_r > gdnc_pkg::DAYS_BEFORE[lp_r][m_inc]);

  always_comb begin
    logic            year_ok;
    logic            month_ok;
    logic [MONW-1:0] mon_idx;
    logic [4:0]      dim;
    logic            day_ok;
    year_ok  = (32'(req_r.year_in) >= gdnc_pkg::BASE_YEAR) &&
               (32'(req_r.year_in) <= MAX_YEAR);
    month_ok = (req_r.month_in != '0) && (req_r.month_in <= gdnc_pkg::MONTH_DEC);
    mon_idx  = month_ok ? req_r.month_in : gdnc_pkg::MONTH_JAN;
    dim      = (req_r.month_in == gdnc_pkg::MONTH_FEB && lp_r) ?
               5'(gdnc_pkg::FEB_LEAP_DAYS) : gdnc_pkg::MONTH_LEN[mon_idx];
    day_ok   = (req_r.day_in != '0) && (req_r.day_in <= dim);
    res_c    = '0;
    unique case (cmd.res_sel)
      gdnc_pkg::RES_NUM: begin
        if (year_ok && month_ok && day_ok) begin
          res_c.status         = gdnc_pkg::STATUS_OK;
          res_c.day_number_out = 22'(32'(wyd_r)
                                     + 32'(gdnc_pkg::DAYS_BEFORE[lp_r][mon_idx])
                                     + 32'(req_r.day_in));
        end else begin
          res_c.status = gdnc_pkg::STATUS_BAD_DATE;
        end
      end
      gdnc_pkg::RES_DATE: begin
        res_c.status    = gdnc_pkg::STATUS_OK;
        res_c.day_out   = 5'(doy_r - gdnc_pkg::DAYS_BEFORE[lp_r][m_r]);
        res_c.month_out = m_r;
        res_c.year_out  = 14'(op_r);
      end
      gdnc_pkg::RES_RANGE: begin
        res_c.status = gdnc_pkg::STATUS_BAD_NUM;
      end
      default: begin
        res_c = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= in_data;
      y_r    <= '0;
      base_r <= '0;
      bit_r  <= BCW'(YB - 1);
      if (in_data.action == gdnc_pkg::ACT_TO_DATE) begin
        op_r <= OPW'(YB'(1) << (YB - 1));
      end else begin
        op_r <= OPW'(in_data.year_in);
      end
    end
    if (cmd.q_en) begin
      q100_r <= QW'(qprod >> gdnc_pkg::DIV100_SH);
    end
    if (cmd.leap_en) begin
      lp_r <= leap_c;
      op_r <= OPW'(req_r.year_in) - OPW'(gdnc_pkg::BASE_YEAR);
    end
    if (cmd.w_en) begin
      wyd_r <= wyd_c;
    end
    if (cmd.cmp_en) begin
      y_r   <= y_new;
      bit_r <= bit_r - 1'b1;
      if (lt_c) begin
        base_r <= wyd_r;
      end
      if (bit_r == '0) begin
        op_r <= OPW'(y_new) + OPW'(gdnc_pkg::BASE_YEAR);
      end else begin
        op_r <= OPW'(y_new | (YB'(1) << (bit_r - 1'b1)));
      end
    end
    if (cmd.yleap_en) begin
      lp_r  <= leap_c;
      doy_r <= DOYW'(32'(req_r.day_number_in) - 32'(base_r));
    end
    if (cmd.out_load) begin
      out_r <= res_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r <= gdnc_pkg::MONTH_JAN;
    end else if (cmd.yleap_en) begin
      m_r <= gdnc_pkg::MONTH_JAN;
    end else if (cmd.m_step) begin
      m_r <= m_inc;
    end
  end

  assign out_data = out_r;

`ifndef SYNTHESIS
  a_doy_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.yleap_en |=> (doy_r != '0 && doy_r <= 9'd366))
    else $error("day of year out of range after year search");

  a_month_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.m_step |=> (m_r >= 4'd2 && m_r <= gdnc_pkg::MONTH_DEC))
    else $error("month search ran past december");

  a_search_base: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cmp_en |=> (32'(base_r) < 32'(req_r.day_number_in)))
    else $error("year base not below day number");
`endif

endmodule

/* design/gregorian_day_number_converter_top.sv */
// channel   dir  handshake           payload
// in_       in   in_valid/in_stall   gdnc_in_t  (action, day, month, year, day number)
// out_      out  out_valid/out_stall gdnc_out_t (status, day number, day, month, year)
//
// one request at a time; a finished result waits in the output register while
// the next request is taken
// date to day number: states LQ, LP, WQ, WS and FIN0 from acceptance to result
// day number to date: range check, then a year search over Y bits (14 at year
// limit 9999) and a month search; the shared days-in-years unit serves both
// rst_n is synchronous; out_stall only holds the result and the final state
module gregorian_day_number_converter_top #(
  parameter int unsigned MAX_YEAR = gdnc_pkg::MAX_YEAR_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  gdnc_pkg::gdnc_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output gdnc_pkg::gdnc_out_t out_data
);

  gdnc_pkg::gdnc_cmd_t cmd;
  gdnc_pkg::gdnc_sts_t sts;

  gdnc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_data.action),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  gdnc_dp #(
    .MAX_YEAR (MAX_YEAR)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

/* tb/gdnc_checker.sv */
module gdnc_checker #(
  parameter int unsigned MAX_YEAR = gdnc_pkg::MAX_YEAR_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  gdnc_pkg::gdnc_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  gdnc_pkg::gdnc_out_t out_data,
  output int                  fail_count,
  output int                  pending,
  output int                  checked
);

  gdnc_pkg::gdnc_out_t expected_results[$];

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
  end

  function automatic int unsigned days_in_years(input int unsigned n);
    return n * gdnc_pkg::DAYS_PER_YEAR + n / 4 - n / gdnc_pkg::CENTURY
           + n / gdnc_pkg::QUAD_CENTURY;
  endfunction

  function automatic bit is_leap(input int unsigned y);
    return ((y % 4 == 0) && (y % gdnc_pkg::CENTURY != 0)) ||
           (y % gdnc_pkg::QUAD_CENTURY == 0);
  endfunction

  function automatic int unsigned month_days(input int unsigned m, input bit lp);
    case (m)
      32'(gdnc_pkg::MONTH_FEB): return lp ? gdnc_pkg::FEB_LEAP_DAYS : 28;
      4, 6, 9, 11: return 30;
      default: return 31;
    endcase
  endfunction

  function automatic gdnc_pkg::gdnc_out_t convert_date(input gdnc_pkg::gdnc_in_t req);
    gdnc_pkg::gdnc_out_t res;
    int unsigned         day;
    int unsigned         month;
    int unsigned         year;
    int unsigned         num;
    int unsigned         last;
    int unsigned         base;
    int unsigned         doy;
    int unsigned         y;
    int unsigned         m;
    bit                  lp;
    res = '0;
    if (req.action == gdnc_pkg::ACT_TO_NUM) begin
      day   = 32'(req.day_in);
      month = 32'(req.month_in);
      year  = 32'(req.year_in);
      if (year < gdnc_pkg::BASE_YEAR || year > MAX_YEAR ||
          month < 32'(gdnc_pkg::MONTH_JAN) || month > 32'(gdnc_pkg::MONTH_DEC)) begin
        res.status = gdnc_pkg::STATUS_BAD_DATE;
      end else begin
        lp = is_leap(year);
        if (day < 1 || day > month_days(month, lp)) begin
          res.status = gdnc_pkg::STATUS_BAD_DATE;
        end else begin
          num = days_in_years(year - gdnc_pkg::BASE_YEAR) + day;
          for (m = 32'(gdnc_pkg::MONTH_JAN); m < month; m++) num += month_days(m, lp);
          res.status         = gdnc_pkg::STATUS_OK;
          res.day_number_out = num[gdnc_pkg::NUMW-1:0];
        end
      end
    end else begin
      num  = 32'(req.day_number_in);
      last = days_in_years(MAX_YEAR - gdnc_pkg::BASE_YEAR + 1);
      if (num == 0 || num > last) begin
        res.status = gdnc_pkg::STATUS_BAD_NUM;
      end else begin
        y    = num / gdnc_pkg::DAYS_PER_YEAR;
        base = days_in_years(y);
        while (base >= num) begin
          y--;
          base = days_in_years(y);
        end
        year = gdnc_pkg::BASE_YEAR + y;
        doy  = num - base;
        lp   = is_leap(year);
        m    = 32'(gdnc_pkg::MONTH_JAN);
        while (m < 32'(gdnc_pkg::MONTH_DEC) && doy > month_days(m, lp)) begin
          doy -= month_days(m, lp);
          m++;
        end
        res.status    = gdnc_pkg::STATUS_OK;
        res.day_out   = doy[gdnc_pkg::DAYW-1:0];
        res.month_out = m[gdnc_pkg::MONW-1:0];
        res.year_out  = year[gdnc_pkg::YEARW-1:0];
      end
    end
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    gdnc_pkg::gdnc_out_t want;
    if (rst_n && in_valid && !in_stall) expected_results.push_back(convert_date(in_data));
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        fail_count++;
        $display("%0t: result with no request pending, expected none, got %h", $time,
                 out_data);
      end else begin
        want = expected_results.pop_front();
        checked++;
        check_field("status", 32'(want.status), 32'(out_data.status));
        check_field("day_number_out", 32'(want.day_number_out),
                    32'(out_data.day_number_out));
        check_field("day_out", 32'(want.day_out), 32'(out_data.day_out));
        check_field("month_out", 32'(want.month_out), 32'(out_data.month_out));
        check_field("year_out", 32'(want.year_out), 32'(out_data.year_out));
      end
    end
    pending = expected_results.size();
  end

endmodule

/* tb/tb_gregorian_day_number_converter_top.sv */
module tb_gregorian_day_number_converter_top;

  localparam int unsigned LAST_DAY_NUMBER = 3067671;
  localparam int          LONG_HOLD       = 300;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  gdnc_pkg::gdnc_in_t  in_data;
  logic                out_valid;
  logic                out_stall;
  gdnc_pkg::gdnc_out_t out_data;

  int fail_count;
  int pending;
  int checked;
  int to_num_count;
  int to_date_count;
  bit calm;
  bit hold_request;

  gregorian_day_number_converter_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  gdnc_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending),
    .checked   (checked)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #15000000;
    $display("Some tests failed");
    $finish;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // output side: random stalls, plus one long hold on request
  initial begin : receiver
    int   hold_left;
    int   stall_left;
    logic stall_next;
    hold_left  = 0;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left    = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (calm) begin
        stall_next = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        stall_next = 1'b1;
      end else begin
        stall_next = 1'b0;
        if ($urandom_range(0, 3) == 0) stall_left = idle_len();
      end
      out_stall <= stall_next;
    end
  end

  task automatic send_request(input gdnc_pkg::gdnc_in_t req);
    int gap;
    gap = (calm || $urandom_range(0, 2) != 0) ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    if (req.action == gdnc_pkg::ACT_TO_NUM) to_num_count++;
    else to_date_count++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_fields(input logic act, input int unsigned d, input int unsigned m,
                             input int unsigned y, input int unsigned num);
    gdnc_pkg::gdnc_in_t req;
    logic [63:0]        raw;
    raw               = {$urandom, $urandom};
    req               = raw[$bits(gdnc_pkg::gdnc_in_t)-1:0];
    req.action        = act;
    req.day_in        = d[gdnc_pkg::DAYW-1:0];
    req.month_in      = m[gdnc_pkg::MONW-1:0];
    req.year_in       = y[gdnc_pkg::YEARW-1:0];
    req.day_number_in = num[gdnc_pkg::NUMW-1:0];
    send_request(req);
  endtask

  function automatic gdnc_pkg::gdnc_in_t random_request();
    gdnc_pkg::gdnc_in_t req;
    logic [63:0]        raw;
    int                 r;
    raw = {$urandom, $urandom};
    req = raw[$bits(gdnc_pkg::gdnc_in_t)-1:0];
    r   = $urandom_range(0, 99);
    if (r < 35) begin
      req.action   = gdnc_pkg::ACT_TO_NUM;
      req.year_in  = gdnc_pkg::YEARW'($urandom_range(gdnc_pkg::BASE_YEAR,
                                                     gdnc_pkg::MAX_YEAR_DEF));
      req.month_in = gdnc_pkg::MONW'($urandom_range(32'(gdnc_pkg::MONTH_JAN),
                                                    32'(gdnc_pkg::MONTH_DEC)));
      req.day_in   = gdnc_pkg::DAYW'($urandom_range(1, 31));
    end else if (r < 50) begin
      req.action   = gdnc_pkg::ACT_TO_NUM;
      req.year_in  = gdnc_pkg::YEARW'($urandom_range(0, 1) ? 100 * $urandom_range(16, 99)
                                                           : 4 * $urandom_range(401, 2499));
      req.month_in = $urandom_range(0, 1) ? gdnc_pkg::MONTH_FEB
                                          : gdnc_pkg::MONW'($urandom_range(0, 15));
      req.day_in   = gdnc_pkg::DAYW'($urandom_range(0, 1) ? $urandom_range(28, 31)
                                                          : $urandom_range(0, 1));
    end else if (r < 60) begin
      req.action = gdnc_pkg::ACT_TO_NUM;
    end else if (r < 88) begin
      req.action        = gdnc_pkg::ACT_TO_DATE;
      req.day_number_in = gdnc_pkg::NUMW'($urandom_range(1, LAST_DAY_NUMBER));
    end else if (r < 95) begin
      req.action        = gdnc_pkg::ACT_TO_DATE;
      req.day_number_in = gdnc_pkg::NUMW'($urandom_range(0, 1) ? $urandom_range(0, 800)
                          : $urandom_range(LAST_DAY_NUMBER - 800, LAST_DAY_NUMBER + 800));
    end else begin
      req.action = gdnc_pkg::ACT_TO_DATE;
    end
    return req;
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    calm          = 1'b0;
    hold_request  = 1'b0;
    to_num_count  = 0;
    to_date_count = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed dates
    send_fields(gdnc_pkg::ACT_TO_NUM, 1, 1, 1601, 0);
    send_fields(gdnc_pkg::ACT_TO_NUM, 31, 12, 9999, 22'h3fffff);
    send_fields(gdnc_pkg::ACT_TO_NUM, 29, 2, 2000, 0);
    send_fields(gdnc_pkg::ACT_TO_NUM, 29, 2, 1900, 0);
    send_fields(gdnc_pkg::ACT_TO_NUM, 29, 2, 2024, 0);
    send_fields(gdnc_pkg::ACT_TO_NUM, 29, 2, 2023, 0);
    send_fields(gdnc_pkg::ACT_TO_NUM, 0, 1, 2000, 0);
    send_fields(gdnc_pkg::ACT_TO_NUM, 31, 4, 2000, 0);
    send_fields(gdnc_pkg::ACT_TO_NUM, 1, 0, 2000, 0);
    send_fields(gdnc_pkg::ACT_TO_NUM, 1, 13, 2000, 0);
    send_fields(gdnc_pkg::ACT_TO_NUM, 31, 1, 1600, 0);
    send_fields(gdnc_pkg::ACT_TO_NUM, 1, 1, 10000, 0);
    send_fields(gdnc_pkg::ACT_TO_NUM, 0, 0, 0, 0);
    send_fields(gdnc_pkg::ACT_TO_NUM, 31, 15, 16383, 22'h3fffff);
    // directed day numbers
    send_fields(gdnc_pkg::ACT_TO_DATE, 0, 0, 0, 0);
    send_fields(gdnc_pkg::ACT_TO_DATE, 31, 15, 16383, 1);
    send_fields(gdnc_pkg::ACT_TO_DATE, 0, 0, 0, 365);
    send_fields(gdnc_pkg::ACT_TO_DATE, 0, 0, 0, 366);
    send_fields(gdnc_pkg::ACT_TO_DATE, 0, 0, 0, 145791);
    send_fields(gdnc_pkg::ACT_TO_DATE, 0, 0, 0, LAST_DAY_NUMBER);
    send_fields(gdnc_pkg::ACT_TO_DATE, 0, 0, 0, LAST_DAY_NUMBER + 1);
    send_fields(gdnc_pkg::ACT_TO_DATE, 0, 0, 0, 22'h3fffff);

    for (int i = 0; i < 600; i++) begin
      if (i == 60) hold_request = 1'b1;
      send_request(random_request());
    end
    drain();

    calm = 1'b1;
    for (int i = 0; i < 300; i++) send_request(random_request());
    calm = 1'b0;
    drain();

    for (int i = 0; i < 800; i++) send_request(random_request());

    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    $display("ran %0d date-to-number and %0d number-to-date requests, %0d results checked",
             to_num_count, to_date_count, checked);
    $display("covered bad dates, out-of-range day numbers, a long output hold and idle-free runs");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* gregorian_day_number_converter_top.f */
design/gdnc_pkg.sv
design/gdnc_ctrl.sv
design/gdnc_dp.sv
design/gregorian_day_number_converter_top.sv
tb/gdnc_checker.sv
tb/tb_gregorian_day_number_converter_top.sv
